FILE: design/fbca_pkg.sv
// Shared types and constants for the block chain allocator.
package fbca_pkg;

	localparam int NUM_BLOCKS  = 1024;
	localparam int BLK_W       = 10;
	localparam int CNT_W       = 11;
	localparam int LINK_W      = 16;
	localparam int BLOCK_BYTES = 512;
	localparam int BB_SH       = $clog2(BLOCK_BYTES);
	localparam int SIZE_W      = 19;

	localparam logic [LINK_W-1:0] LINK_FREE = 16'hffff;
	localparam logic [LINK_W-1:0] LINK_END  = 16'hfffe;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_TOO_LARGE  = 2'd1,
		STAT_ZERO_SIZE  = 2'd2,
		STAT_START_FREE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC,
		ST_ALLOC_END,
		ST_REL_WALK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [SIZE_W-1:0] size_bytes;
		logic [BLK_W-1:0]  start_block;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic [BLK_W-1:0] first_block;
		logic [CNT_W-1:0] free_count;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [BLK_W-1:0]  waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [BLK_W-1:0]  raddr;
	} ram_req_t;

endpackage

FILE: design/fbca_link_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module fbca_link_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/fbca_ctrl.sv
// Sequencer for allocate, release and clear over the link table RAM.
module fbca_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  fbca_pkg::cmd_t            cmd,
	output logic                      res_valid,
	input  logic                      res_take,
	output fbca_pkg::res_t            res,
	output fbca_pkg::ram_req_t        ram_req,
	input  logic [fbca_pkg::LINK_W-1:0] ram_rdata
);
	import fbca_pkg::*;

	localparam int SZ1_W = SIZE_W + 1;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   scan_q, need_q, found_q, steps_q, free_q;
	logic [BLK_W-1:0]   prev_q, head_q, clr_q;
	logic               first_q, clr_resp_q;
	status_t            status_q;
	logic               rd_v_s1, hit_s1;
	logic [BLK_W-1:0]   rd_addr_s1;
	logic [LINK_W-1:0]  fwd_s1;

	logic [LINK_W-1:0]  link;
	logic [SZ1_W-1:0]   size_ext, need_sum, cap_bytes;
	logic [CNT_W-1:0]   need;
	logic               accept, size_zero, too_large;
	logic               is_free, alloc_hit, alloc_last, alloc_out;
	logic               rel_stop, rel_step, rel_end;
	logic               clr_done;

	// same-cycle write to the address being read: take the written word
	assign link      = hit_s1 ? fwd_s1 : ram_rdata;
	assign is_free   = (link == LINK_FREE);

	assign accept    = (state_q == ST_IDLE) && cmd_valid;
	assign size_ext  = SZ1_W'(cmd.size_bytes);
	assign size_zero = (cmd.size_bytes == '0);
	assign cap_bytes = {free_q, BB_SH'(0)};
	assign too_large = !(size_ext < cap_bytes);
	assign need_sum  = size_ext + SZ1_W'(BLOCK_BYTES - 1);
	assign need      = need_sum[SZ1_W-1:BB_SH];

	assign alloc_hit  = (state_q == ST_ALLOC) && rd_v_s1 && is_free;
	assign alloc_last = alloc_hit && ((found_q + CNT_W'(1)) == need_q);
	assign alloc_out  = (state_q == ST_ALLOC) && !rd_v_s1
		&& (scan_q == CNT_W'(NUM_BLOCKS));

	assign rel_stop = (state_q == ST_REL_WALK) && is_free;
	assign rel_step = (state_q == ST_REL_WALK) && !is_free;
	assign rel_end  = rel_step && ((link >= LINK_W'(NUM_BLOCKS))
		|| ((steps_q + CNT_W'(1)) == CNT_W'(NUM_BLOCKS)));

	assign clr_done = (clr_q == BLK_W'(NUM_BLOCKS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = clr_resp_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.action)
						ACT_ALLOC: begin
							state_d = (size_zero || too_large) ? ST_RESP : ST_ALLOC;
						end
						ACT_RELEASE: state_d = ST_REL_WALK;
						ACT_CLEAR:   state_d = ST_CLEAR;
						default:     state_d = ST_RESP;
					endcase
				end
			end
			ST_ALLOC: begin
				if (alloc_last || alloc_out) begin
					state_d = ST_ALLOC_END;
				end
			end
			ST_ALLOC_END: state_d = ST_RESP;
			ST_REL_WALK: begin
				if (rel_stop || rel_end) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and RAM requests
	always_comb begin
		ram_req   = '0;
		cmd_ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESP);
		res       = '{status: status_q, first_block: head_q, free_count: free_q};
		case (state_q)
			ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
				ram_req.wdata = LINK_FREE;
			end
			ST_IDLE: begin
				ram_req.re    = cmd_valid && (cmd.action == ACT_RELEASE);
				ram_req.raddr = cmd.start_block;
			end
			ST_ALLOC: begin
				// link the previous block to the one just found
				ram_req.we    = alloc_hit && (found_q != '0);
				ram_req.waddr = prev_q;
				ram_req.wdata = LINK_W'(rd_addr_s1);
				ram_req.re    = (scan_q != CNT_W'(NUM_BLOCKS));
				ram_req.raddr = scan_q[BLK_W-1:0];
			end
			ST_ALLOC_END: begin
				ram_req.we    = (found_q != '0);
				ram_req.waddr = prev_q;
				ram_req.wdata = LINK_END;
			end
			ST_REL_WALK: begin
				ram_req.we    = rel_step;
				ram_req.waddr = rd_addr_s1;
				ram_req.wdata = LINK_FREE;
				ram_req.re    = rel_step && !rel_end;
				ram_req.raddr = link[BLK_W-1:0];
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			clr_resp_q <= 1'b0;
			free_q     <= CNT_W'(NUM_BLOCKS);
			rd_v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= ram_req.re;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + BLK_W'(1);
				if (clr_done) begin
					free_q <= CNT_W'(NUM_BLOCKS);
				end
			end
			if (accept && (cmd.action == ACT_CLEAR)) begin
				clr_q      <= '0;
				clr_resp_q <= 1'b1;
			end
			if (alloc_hit && (free_q != '0)) begin
				free_q <= free_q - CNT_W'(1);
			end
			if (rel_step) begin
				free_q <= free_q + CNT_W'(1);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		rd_addr_s1 <= ram_req.raddr;
		hit_s1     <= ram_req.re && ram_req.we && (ram_req.raddr == ram_req.waddr);
		fwd_s1     <= ram_req.wdata;
		if (accept) begin
			need_q   <= need;
			found_q  <= '0;
			scan_q   <= '0;
			steps_q  <= '0;
			head_q   <= '0;
			first_q  <= 1'b1;
			status_q <= STAT_OK;
			if (cmd.action == ACT_ALLOC) begin
				if (size_zero) begin
					status_q <= STAT_ZERO_SIZE;
				end else if (too_large) begin
					status_q <= STAT_TOO_LARGE;
				end
			end
		end
		if ((state_q == ST_ALLOC) && ram_req.re) begin
			scan_q <= scan_q + CNT_W'(1);
		end
		if (alloc_hit) begin
			if (found_q == '0) begin
				head_q <= rd_addr_s1;
			end
			prev_q  <= rd_addr_s1;
			found_q <= found_q + CNT_W'(1);
		end
		if (rel_step) begin
			steps_q <= steps_q + CNT_W'(1);
			first_q <= 1'b0;
		end
		if (rel_stop && first_q) begin
			status_q <= STAT_START_FREE;
		end
	end

endmodule

FILE: design/fat_block_chain_allocator.sv
// Top level of the block chain allocator: sequencer, link table RAM, result register.
// Allocate ends once the scan has read the last block it takes or run off the table; release
// ends when the walk reaches the end marker, a link off the table or a free block, or after a
// full table of steps; clear rewrites the whole table; others go straight to the response.
// One transaction is worked at a time; the scan and the chain walk read one link per cycle.
// After reset a clearing pass writes all NUM_BLOCKS entries free, with cmd_ready low.
module fat_block_chain_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  fbca_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output fbca_pkg::res_t res
);
	import fbca_pkg::*;

	ram_req_t          ram_req;
	logic [LINK_W-1:0] ram_rdata;
	logic              seq_valid, seq_take;
	res_t              seq_res;
	logic              res_valid_q;
	res_t              res_q;

	// link table: one link word per block, free marker, end marker or next block
	fbca_link_ram #(
		.DEPTH (NUM_BLOCKS),
		.DW    (LINK_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// sequencer holds the free count and walks the table
	fbca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (seq_valid),
		.res_take  (seq_take),
		.res       (seq_res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// result register frees the sequencer to take the next transaction
	assign seq_take = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (seq_valid && seq_take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_valid && seq_take) begin
			res_q <= seq_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	// one transaction in flight: after an accept the sequencer is busy
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted while sequencer busy");

	// free count never exceeds the table size
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.free_count <= CNT_W'(NUM_BLOCKS)))
		else $error("free count above table size");

	// a chain head is reported only with an ok status
	a_head_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.first_block != '0)) |-> (res.status == STAT_OK))
		else $error("head block on failed transaction");

	// the sequencer never writes or reads the RAM while responding
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		seq_valid |-> (!ram_req.we && !ram_req.re))
		else $error("RAM access during response");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the block chain allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;
	import fbca_pkg::*;

	// Action code 3 has no meaning; the block must answer ok and change nothing.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Row marks for the directed table: the expected result is typed in, or comes from the model.
	localparam logic ROW_TYPED = 1'b1;
	localparam logic ROW_MODEL = 1'b0;

	// Guard against a hung block. The slowest correct run is about 585 transactions of a
	// full-table scan plus sender gaps and receiver stalls, plus the clearing pass after
	// reset; this is several times that.
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RANDOM_PER_PHASE = 140;

	logic   clk;
	logic   arst_n    = 1'b0;
	logic   cmd_valid = 1'b0;
	logic   cmd_ready;
	cmd_t   cmd       = '0;
	logic   res_valid;
	logic   res_ready = 1'b0;
	res_t   res;

	fat_block_chain_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle rates in percent, changed per phase by the stimulus.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	// Shadow of the block: link table, free count, and the heads handed out so far.
	logic [LINK_W-1:0] link_shadow [NUM_BLOCKS];
	int unsigned       free_shadow;
	int unsigned       chain_heads [$];

	// Results owed by the block, oldest first.
	res_t        owed_results [$];
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;

	typedef struct packed {
		cmd_t c;
		logic typed;
		res_t want;
	} step_row_t;

	localparam int DIR_ROWS = 25;
	step_row_t dir_rows [DIR_ROWS];

	function automatic void free_whole_table();
		for (int b = 0; b < NUM_BLOCKS; b++)
			link_shadow[b] = LINK_FREE;
		free_shadow = NUM_BLOCKS;
		chain_heads.delete();
	endfunction

	// Applies one transaction to the shadow table and returns the answer the block owes.
	function automatic res_t apply_table_op(input cmd_t c);
		res_t              r;
		int unsigned       need;
		int unsigned       cur;
		int unsigned       prev;
		int unsigned       scan;
		logic [LINK_W-1:0] nxt;
		r.status      = STAT_OK;
		r.first_block = '0;
		prev          = 0;
		scan          = 0;
		case (c.action)
			ACT_ALLOC: begin
				if (c.size_bytes == 0) begin
					r.status = STAT_ZERO_SIZE;
				end else if (c.size_bytes >= free_shadow * BLOCK_BYTES) begin
					r.status = STAT_TOO_LARGE;
				end else begin
					need = (c.size_bytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
					for (int k = 0; k < need; k++) begin
						// lowest free block at or above the scan point
						cur = scan;
						while (cur < NUM_BLOCKS && link_shadow[cur] != LINK_FREE)
							cur++;
						if (cur >= NUM_BLOCKS)
							break;
						if (k == 0)
							r.first_block = cur[BLK_W-1:0];
						else
							link_shadow[prev] = cur[LINK_W-1:0];
						link_shadow[cur] = LINK_END;
						if (free_shadow > 0)
							free_shadow--;
						prev = cur;
						scan = cur + 1;
					end
					chain_heads.push_back(32'(r.first_block));
				end
			end
			ACT_RELEASE: begin
				cur = 32'(c.start_block);
				if (link_shadow[cur] == LINK_FREE) begin
					r.status = STAT_START_FREE;
				end else begin
					// Walk stops at the end marker, a free block, a link off the table,
					// or after a full table of steps.
					for (int steps = 0; steps < NUM_BLOCKS; steps++) begin
						nxt = link_shadow[cur];
						link_shadow[cur] = LINK_FREE;
						free_shadow++;
						if (nxt == LINK_END || nxt == LINK_FREE || nxt >= NUM_BLOCKS)
							break;
						cur = 32'(nxt);
						if (link_shadow[cur] == LINK_FREE)
							break;
					end
				end
			end
			ACT_CLEAR: free_whole_table();
			default: ;
		endcase
		r.free_count = free_shadow[CNT_W-1:0];
		return r;
	endfunction

	// Random mix: mostly small allocations and releases of known heads, plus
	// stale or free starts, zero sizes, boundary sizes, unused codes and rare clears.
	function automatic cmd_t make_random_cmd();
		cmd_t        c;
		logic [31:0] rnd;
		int unsigned pick;
		int unsigned idx;
		int unsigned lim;
		int unsigned sz;
		rnd           = $urandom;
		c.action      = ACT_ALLOC;
		c.size_bytes  = rnd[SIZE_W-1:0];
		c.start_block = rnd[31:32-BLK_W];
		pick          = $urandom_range(99);
		if (pick < 40) begin
			c.size_bytes = SIZE_W'($urandom_range(3000, 1));
		end else if (pick < 45) begin
			// full-width size, mostly too large
		end else if (pick < 80) begin
			c.action = ACT_RELEASE;
			if (chain_heads.size() != 0) begin
				idx           = $urandom_range(chain_heads.size() - 1);
				c.start_block = BLK_W'(chain_heads[idx]);
				chain_heads.delete(idx);
			end
		end else if (pick < 87) begin
			c.action = ACT_RELEASE;
		end else if (pick < 90) begin
			c.size_bytes = '0;
		end else if (pick < 93) begin
			c.action = ACT_UNUSED;
		end else if (pick < 95) begin
			c.action = ACT_CLEAR;
		end else begin
			// right at or just below the free capacity
			lim = free_shadow * BLOCK_BYTES;
			if (lim == 0)
				sz = $urandom_range(BLOCK_BYTES, 1);
			else
				sz = lim - $urandom_range(1, 0);
			c.size_bytes = sz[SIZE_W-1:0];
		end
		return c;
	endfunction

	// Offers one transaction, holding it until accepted, then books the owed result.
	// Always entered at a rising edge, so cmd_valid gets one assignment per step.
	task automatic send_cmd(input cmd_t c, input logic typed, input res_t typed_res);
		res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		r = apply_table_op(c);
		owed_results.push_back(typed ? typed_res : r);
	endtask

	task automatic wait_results_drained();
		cmd_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, and every accepted result checked against the oldest owed one.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing owed: status %0d first %0d free %0d",
					$time, res.status, res.first_block, res.free_count);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				if (res.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, res.status);
					mismatches++;
				end
				if (res.first_block !== want.first_block) begin
					$display("%0t: first_block expected %0d got %0d",
						$time, want.first_block, res.first_block);
					mismatches++;
				end
				if (res.free_count !== want.free_count) begin
					$display("%0t: free_count expected %0d got %0d",
						$time, want.free_count, res.free_count);
					mismatches++;
				end
			end
		end
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results owed", $time, owed_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		// Directed table, starting from the reset state (all free, 1024 blocks).
		// Typed rows are read straight off the rules; the rest go through the shadow model.
		dir_rows[0]  = {ACT_ALLOC,   19'd0,      10'd0,    ROW_TYPED,
			STAT_ZERO_SIZE,  10'd0, 11'd1024};
		dir_rows[1]  = {ACT_RELEASE, 19'd0,      10'd0,    ROW_TYPED,
			STAT_START_FREE, 10'd0, 11'd1024};
		dir_rows[2]  = {ACT_UNUSED,  19'h7ffff,  10'h3ff,  ROW_TYPED,
			STAT_OK,         10'd0, 11'd1024};
		// largest size takes the whole table
		dir_rows[3]  = {ACT_ALLOC,   19'd524287, 10'd0,    ROW_TYPED,
			STAT_OK,         10'd0, 11'd0};
		dir_rows[4]  = {ACT_ALLOC,   19'd1,      10'd0,    ROW_TYPED,
			STAT_TOO_LARGE,  10'd0, 11'd0};
		// tail block, then the middle of the chain, then its head
		dir_rows[5]  = {ACT_RELEASE, 19'd0,      10'd1023, ROW_TYPED,
			STAT_OK,         10'd0, 11'd1};
		dir_rows[6]  = {ACT_RELEASE, 19'd0,      10'd512,  ROW_MODEL, 23'd0};
		dir_rows[7]  = {ACT_RELEASE, 19'd0,      10'd0,    ROW_MODEL, 23'd0};
		dir_rows[8]  = {ACT_ALLOC,   19'd512,    10'd0,    ROW_MODEL, 23'd0};
		dir_rows[9]  = {ACT_ALLOC,   19'd513,    10'd0,    ROW_MODEL, 23'd0};
		dir_rows[10] = {ACT_ALLOC,   19'd1023,   10'd0,    ROW_MODEL, 23'd0};
		// exactly free * 512 is refused, one byte less is taken
		dir_rows[11] = {ACT_ALLOC,   19'd521728, 10'd0,    ROW_TYPED,
			STAT_TOO_LARGE,  10'd0, 11'd1019};
		dir_rows[12] = {ACT_ALLOC,   19'd521727, 10'd0,    ROW_MODEL, 23'd0};
		dir_rows[13] = {ACT_CLEAR,   19'd0,      10'd0,    ROW_TYPED,
			STAT_OK,         10'd0, 11'd1024};
		// fragmented chain, stale links, release of a block already freed
		dir_rows[14] = {ACT_ALLOC,   19'd1024,   10'd0,    ROW_MODEL, 23'd0};
		dir_rows[15] = {ACT_ALLOC,   19'd512,    10'd0,    ROW_MODEL, 23'd0};
		dir_rows[16] = {ACT_RELEASE, 19'd0,      10'd0,    ROW_MODEL, 23'd0};
		dir_rows[17] = {ACT_ALLOC,   19'd1536,   10'd0,    ROW_MODEL, 23'd0};
		dir_rows[18] = {ACT_RELEASE, 19'd0,      10'd2,    ROW_MODEL, 23'd0};
		dir_rows[19] = {ACT_RELEASE, 19'd0,      10'd1,    ROW_MODEL, 23'd0};
		dir_rows[20] = {ACT_RELEASE, 19'd0,      10'd0,    ROW_MODEL, 23'd0};
		dir_rows[21] = {ACT_RELEASE, 19'd0,      10'd3,    ROW_MODEL, 23'd0};
		dir_rows[22] = {ACT_ALLOC,   19'd262144, 10'd0,    ROW_MODEL, 23'd0};
		dir_rows[23] = {ACT_RELEASE, 19'd0,      10'd5,    ROW_MODEL, 23'd0};
		dir_rows[24] = {ACT_CLEAR,   19'd0,      10'd0,    ROW_TYPED,
			STAT_OK,         10'd0, 11'd1024};

		free_whole_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// cmd_ready stays low through the clearing pass; the handshake wait covers it
		for (int i = 0; i < DIR_ROWS; i++)
			send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
		wait_results_drained();

		// Random phases: no idling, sender idle, receiver stalling, both.
		// Between phases the sender holds off until every owed result is in.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_cmd(make_random_cmd(), ROW_MODEL, '0);
			wait_results_drained();
		end

		// let any stray result show up
		repeat (NUM_BLOCKS + 8) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: fat_block_chain_allocator.f
design/fbca_pkg.sv
design/fbca_link_ram.sv
design/fbca_ctrl.sv
design/fat_block_chain_allocator.sv
test/testbench.sv
